FILE: hdl/mmsp_pkg.sv
`timescale 1ns / 1ps
package mmsp_pkg;

    localparam int MAX_DOTS = 4;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_OCT      = 3'd1,
        PH_MODE     = 3'd2,
        PH_NUM      = 3'd3,
        PH_NOTE_ALT = 3'd4,
        PH_NOTE_LEN = 3'd5,
        PH_NOTE_DOT = 3'd6
    } t_phase;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_L    = 2'd1,
        CMD_T    = 2'd2,
        CMD_N    = 2'd3
    } t_cmd;

    localparam logic [1:0] ART_NORMAL   = 2'd0;
    localparam logic [1:0] ART_LEGATO   = 2'd1;
    localparam logic [1:0] ART_STACCATO = 2'd2;

    localparam logic [1:0] ALT_NONE    = 2'd0;
    localparam logic [1:0] ALT_SHARP   = 2'd1;
    localparam logic [1:0] ALT_FLAT    = 2'd2;
    localparam logic [1:0] ALT_NATURAL = 2'd3;

    // controller states
    typedef enum logic [2:0] {
        S_IDLE  = 3'd0,
        S_PARSE = 3'd1,
        S_DIV   = 3'd2,
        S_DOTS  = 3'd3,
        S_OUT   = 3'd4,
        S_EOS   = 3'd5
    } t_state;

    // datapath sequencer states
    typedef enum logic [2:0] {
        D_IDLE = 3'd0,
        D_MUL  = 3'd1,
        D_ADD  = 3'd2,
        D_DIV  = 3'd3,
        D_DOT  = 3'd4,
        D_TONE = 3'd5
    } t_dstate;

    // note request from controller to datapath
    typedef struct packed {
        logic       start;
        logic [6:0] note;
        logic [9:0] len;
        logic [1:0] alt;
        logic [2:0] dots;
        logic       last;
    } t_play_cmd;

    typedef struct packed {
        logic busy;
    } t_play_sts;

    function automatic logic [12:0] freq_lookup(input logic signed [8:0] semi);
        logic [12:0] t [0:90];
        t = '{13'd33, 13'd35, 13'd37, 13'd39, 13'd41, 13'd44, 13'd46, 13'd49,
              13'd52, 13'd55, 13'd58, 13'd62, 13'd65, 13'd69, 13'd73, 13'd78,
              13'd82, 13'd87, 13'd92, 13'd98, 13'd104, 13'd110, 13'd117,
              13'd123, 13'd131, 13'd139, 13'd147, 13'd156, 13'd165, 13'd175,
              13'd185, 13'd196, 13'd208, 13'd220, 13'd233, 13'd247, 13'd262,
              13'd277, 13'd294, 13'd311, 13'd330, 13'd349, 13'd370, 13'd392,
              13'd415, 13'd440, 13'd466, 13'd494, 13'd523, 13'd554, 13'd587,
              13'd622, 13'd659, 13'd698, 13'd740, 13'd784, 13'd831, 13'd880,
              13'd932, 13'd988, 13'd1047, 13'd1109, 13'd1175, 13'd1245,
              13'd1319, 13'd1397, 13'd1480, 13'd1568, 13'd1661, 13'd1760,
              13'd1865, 13'd1976, 13'd2093, 13'd2217, 13'd2349, 13'd2489,
              13'd2637, 13'd2794, 13'd2960, 13'd3136, 13'd3322, 13'd3520,
              13'd3729, 13'd3951, 13'd4186, 13'd4435, 13'd4699, 13'd4978,
              13'd5274, 13'd5588, 13'd5920};
        if (semi >= 9'sd1 && semi <= 9'sd91) begin
            freq_lookup = t[7'(semi - 9'sd1)];
        end else begin
            freq_lookup = 13'd0;
        end
    endfunction

    function automatic logic [3:0] semis_from_c(input logic [2:0] idx);
        case (idx)
            3'd0:    semis_from_c = 4'd9;
            3'd1:    semis_from_c = 4'd11;
            3'd2:    semis_from_c = 4'd0;
            3'd3:    semis_from_c = 4'd2;
            3'd4:    semis_from_c = 4'd4;
            3'd5:    semis_from_c = 4'd5;
            3'd6:    semis_from_c = 4'd7;
            default: semis_from_c = 4'd0;
        endcase
    endfunction

endpackage

FILE: hdl/mmsp_datapath.sv
`timescale 1ns / 1ps
module mmsp_datapath (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  mmsp_pkg::t_play_cmd  i_cmd,
    input  logic [7:0]           i_tempo,
    input  logic [6:0]           i_default_length,
    input  logic [1:0]           i_art_mode,
    input  logic [1:0]           i_global_alt,
    output mmsp_pkg::t_play_sts  o_sts,
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic [12:0]          o_frequency_hz,
    output logic [15:0]          o_tone_ms,
    output logic [15:0]          o_note_ms,
    output logic signed [7:0]    o_note_number,
    output logic                 o_end_of_run
);
    import mmsp_pkg::*;

    t_dstate            r_st;
    logic [17:0]        r_div;
    logic [25:0]        r_rem;
    logic [25:0]        r_quo;
    logic [4:0]         r_cnt;
    logic [2:0]         r_dots;
    logic [23:0]        r_d;
    logic signed [8:0]  r_semi;
    logic [9:0]         r_len;
    logic               r_last;
    logic [7:0]         r_tempo;
    logic [1:0]         r_art;
    logic               r_valid;
    logic [12:0]        r_freq;
    logic [15:0]        r_tone;
    logic [15:0]        r_note;
    logic signed [7:0]  r_nnum;
    logic               r_eor;

    logic signed [8:0]  n_semi;
    logic [26:0]        n_trial;
    logic [26:0]        n_dot;
    logic [26:0]        n_tone;
    logic [16:0]        n_ms;

    // semitone after alterations
    always_comb begin
        n_semi = 9'($signed({2'b0, i_cmd.note}));
        if (i_cmd.alt != ALT_NATURAL) begin
            if (i_global_alt == ALT_SHARP) n_semi = n_semi + 9'sd1;
            else if (i_global_alt == ALT_FLAT) n_semi = n_semi - 9'sd1;
            if (i_cmd.alt == ALT_SHARP) n_semi = n_semi + 9'sd1;
            else if (i_cmd.alt == ALT_FLAT) n_semi = n_semi - 9'sd1;
        end
    end

    // restoring divide step, dot scale, rounding
    always_comb begin
        n_trial = {r_rem, r_quo[25]} - {9'd0, r_div};
        n_dot   = ({3'd0, r_d} + {2'd0, r_d, 1'b0}) >> 1;
        case (r_art)
            ART_LEGATO:   n_tone = ({3'd0, r_d} + 27'd128) >> 8;
            ART_STACCATO: n_tone = ({1'b0, r_d, 2'd0} - {3'd0, r_d} + 27'd512) >> 10;
            default:      n_tone = ({r_d, 3'd0} - {3'd0, r_d} + 27'd1024) >> 11;
        endcase
        n_ms = 17'(({3'd0, r_d} + 27'd128) >> 8);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= D_IDLE;
            r_valid <= 1'b0;
        end else begin
            if (r_valid && i_ready) r_valid <= 1'b0;
            case (r_st)
                D_IDLE: begin
                    // settings are taken with the request
                    if (i_cmd.start) begin
                        r_semi  <= n_semi;
                        r_len   <= (i_cmd.len == 10'd0) ? {3'd0, i_default_length}
                                                        : i_cmd.len;
                        r_dots  <= i_cmd.dots;
                        r_last  <= i_cmd.last;
                        r_tempo <= i_tempo;
                        r_art   <= i_art_mode;
                        r_st    <= D_MUL;
                    end
                end
                D_MUL: begin
                    // tempo times length, zero counts as one
                    r_div <= (r_tempo == 8'd0 || r_len == 10'd0) ? 18'd1
                             : {10'd0, r_tempo} * {8'd0, r_len};
                    r_st  <= D_ADD;
                end
                D_ADD: begin
                    // half the divisor added to the dividend for rounding
                    r_quo <= 26'd61440000 + {9'd0, r_div[17:1]};
                    r_rem <= 26'd0;
                    r_cnt <= 5'd0;
                    r_st  <= D_DIV;
                end
                D_DIV: begin
                    // one quotient bit per cycle, 26 steps
                    if (!n_trial[26]) r_rem <= n_trial[25:0];
                    else r_rem <= {r_rem[24:0], r_quo[25]};
                    r_quo <= {r_quo[24:0], ~n_trial[26]};
                    r_cnt <= r_cnt + 5'd1;
                    if (r_cnt == 5'd25) r_st <= D_DOT;
                end
                D_DOT: begin
                    if (r_cnt == 5'd26) begin
                        // quotient fits 26 bits, clamp to 24
                        r_d   <= (r_quo > 26'hFFFFFF) ? 24'hFFFFFF : r_quo[23:0];
                        r_cnt <= 5'd0;
                    end else if (r_dots != 3'd0) begin
                        r_d    <= (n_dot > 27'hFFFFFF) ? 24'hFFFFFF : n_dot[23:0];
                        r_dots <= r_dots - 3'd1;
                    end else begin
                        r_st <= D_TONE;
                    end
                end
                D_TONE: begin
                    if (!r_valid) begin
                        r_freq  <= freq_lookup(r_semi);
                        r_tone  <= (n_tone > 27'd65535) ? 16'hFFFF : n_tone[15:0];
                        r_note  <= n_ms[16] ? 16'hFFFF : n_ms[15:0];
                        r_nnum  <= r_semi[7:0];
                        r_eor   <= r_last;
                        r_valid <= 1'b1;
                        r_st    <= D_IDLE;
                    end
                end
                default: r_st <= D_IDLE;
            endcase
        end
    end

    assign o_sts.busy     = (r_st != D_IDLE);
    assign o_valid        = r_valid;
    assign o_frequency_hz = r_freq;
    assign o_tone_ms      = r_tone;
    assign o_note_ms      = r_note;
    assign o_note_number  = r_nnum;
    assign o_end_of_run   = r_eor;

    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == D_IDLE && i_cmd.start) |=> r_st == D_MUL) else $error("start lost");
    a_dots_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == D_DOT |-> r_dots <= 3'(MAX_DOTS)) else $error("dots");
    a_div_nz: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == D_DIV |-> r_div != 18'd0) else $error("zero divisor");
endmodule

FILE: hdl/mmsp_ctrl.sv
`timescale 1ns / 1ps
module mmsp_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_char_code,
    input  logic                 i_end_of_string,
    input  mmsp_pkg::t_play_sts  i_sts,
    output mmsp_pkg::t_play_cmd  o_cmd,
    output logic [7:0]           o_tempo,
    output logic [6:0]           o_default_length,
    output logic [1:0]           o_art_mode,
    output logic [1:0]           o_global_alt
);
    import mmsp_pkg::*;

    t_state      r_state, n_state;
    logic [7:0]  r_c;
    logic        r_eos;
    logic [2:0]  r_octave;
    logic [6:0]  r_dlen;
    logic [7:0]  r_tempo;
    logic [1:0]  r_art;
    logic [1:0]  r_galt;
    logic [6:0]  r_note;
    t_phase      r_ph;
    t_cmd        r_pcmd;
    logic [9:0]  r_acc;
    logic [2:0]  r_dots;
    logic [1:0]  r_lalt;
    logic        r_halt;
    logic        r_pend;
    t_play_cmd   r_pc;
    t_play_cmd   r_pc2;

    // next values from the parse step
    logic [2:0]  n_octave;
    logic [6:0]  n_dlen;
    logic [7:0]  n_tempo;
    logic [1:0]  n_art, n_galt;
    logic [6:0]  n_note;
    t_phase      n_ph;
    t_cmd        n_pcmd;
    logic [9:0]  n_acc;
    logic [2:0]  n_dots;
    logic [1:0]  n_lalt;
    logic        n_halt;
    logic        p1, p2;
    t_play_cmd   c1, c2;

    logic [7:0]  c;
    logic        digit;
    logic [13:0] acc_mul;

    // one parse step, up to two note requests
    always_comb begin
        logic do_fin, do_disp, eos;
        logic [6:0] fnote;
        c = (r_c >= 8'h61 && r_c <= 8'h7A) ? r_c - 8'd32 : r_c;
        eos = r_eos || (c == 8'd0);
        digit = (c >= 8'h30 && c <= 8'h39);
        acc_mul = 14'({r_acc, 3'd0}) + 14'({r_acc, 1'b0}) + 14'(c - 8'h30);
        n_octave = r_octave; n_dlen = r_dlen; n_tempo = r_tempo;
        n_art = r_art; n_galt = r_galt; n_note = r_note; n_ph = r_ph;
        n_pcmd = r_pcmd; n_acc = r_acc; n_dots = r_dots; n_lalt = r_lalt;
        n_halt = r_halt;
        p1 = 1'b0; p2 = 1'b0; c1 = '0; c2 = '0;
        do_fin = 1'b0; do_disp = 1'b0; fnote = r_note;
        if (c != 8'd0 && !r_halt) begin
            case (r_ph)
                PH_OCT: begin
                    if (c >= 8'h30 && c <= 8'h37) n_octave = c[2:0];
                    else n_halt = 1'b1;
                    n_ph = PH_IDLE;
                end
                PH_MODE: begin
                    case (c)
                        8'h4C: n_art = ART_LEGATO;
                        8'h4E: n_art = ART_NORMAL;
                        8'h53: n_art = ART_STACCATO;
                        8'h23, 8'h2B: n_galt = ALT_SHARP;
                        8'h2D: n_galt = ALT_FLAT;
                        8'h27: n_galt = ALT_NONE;
                        default: n_halt = 1'b1;
                    endcase
                    n_ph = PH_IDLE;
                end
                PH_NUM: begin
                    if (digit) n_acc = (acc_mul > 14'd999) ? 10'd999 : acc_mul[9:0];
                    else begin do_fin = 1'b1; do_disp = 1'b1; end
                end
                PH_NOTE_ALT, PH_NOTE_LEN, PH_NOTE_DOT: begin
                    if (r_ph == PH_NOTE_ALT &&
                        (c == 8'h23 || c == 8'h2B || c == 8'h2D || c == 8'h27)) begin
                        n_lalt = (c == 8'h2D) ? ALT_FLAT :
                                 (c == 8'h27) ? ALT_NATURAL : ALT_SHARP;
                        n_ph = PH_NOTE_LEN;
                    end else if (r_ph != PH_NOTE_DOT && digit) begin
                        n_acc = (acc_mul > 14'd999) ? 10'd999 : acc_mul[9:0];
                        n_ph = PH_NOTE_LEN;
                    end else if (c == 8'h2E) begin
                        if (r_dots < 3'(MAX_DOTS)) n_dots = r_dots + 3'd1;
                        n_ph = PH_NOTE_DOT;
                    end else begin
                        do_fin = 1'b1; do_disp = 1'b1;
                    end
                end
                default: do_disp = 1'b1;
            endcase
        end
        // finish of the pending command
        if (do_fin) begin
            if (r_ph == PH_NUM) begin
                if (r_pcmd == CMD_L && r_acc >= 10'd1 && r_acc <= 10'd64)
                    n_dlen = r_acc[6:0];
                else if (r_pcmd == CMD_T && r_acc >= 10'd32 && r_acc <= 10'd255)
                    n_tempo = r_acc[7:0];
                else if (r_pcmd == CMD_N && r_acc <= 10'd99) begin
                    n_note = r_acc[6:0];
                    p1 = 1'b1;
                    c1 = '{start: 1'b1, note: r_acc[6:0], len: 10'd0,
                           alt: ALT_NONE, dots: 3'd0, last: 1'b0};
                end
            end else begin
                p1 = 1'b1;
                c1 = '{start: 1'b1, note: r_note, len: r_acc, alt: r_lalt,
                       dots: r_dots, last: 1'b0};
            end
            n_ph = PH_IDLE; n_pcmd = CMD_NONE; n_acc = 10'd0;
            n_dots = 3'd0; n_lalt = ALT_NONE;
        end
        if (do_disp) begin
            n_ph = PH_IDLE; n_pcmd = CMD_NONE; n_acc = 10'd0;
            n_dots = 3'd0; n_lalt = ALT_NONE;
            case (c)
                8'h4F: n_ph = PH_OCT;
                8'h3C: if (r_octave > 3'd0) n_octave = r_octave - 3'd1;
                8'h3E: if (r_octave < 3'd7) n_octave = r_octave + 3'd1;
                8'h4D: n_ph = PH_MODE;
                8'h4C: begin n_ph = PH_NUM; n_pcmd = CMD_L; end
                8'h54: begin n_ph = PH_NUM; n_pcmd = CMD_T; end
                8'h4E: begin n_ph = PH_NUM; n_pcmd = CMD_N; end
                8'h50: begin n_note = 7'd0; n_ph = PH_NOTE_ALT; end
                default: begin
                    if (c >= 8'h41 && c <= 8'h47) begin
                        n_note = 7'(7'd1 + 7'(n_octave) * 7'd12
                                 + 7'(semis_from_c(3'(c - 8'h41))));
                        n_ph = PH_NOTE_ALT;
                    end
                end
            endcase
        end
        // end of string flushes the freshly updated parse state
        if (eos) begin
            if (!n_halt) begin
                fnote = n_note;
                if (n_ph == PH_NUM) begin
                    if (n_pcmd == CMD_L && n_acc >= 10'd1 && n_acc <= 10'd64)
                        n_dlen = n_acc[6:0];
                    else if (n_pcmd == CMD_T && n_acc >= 10'd32 && n_acc <= 10'd255)
                        n_tempo = n_acc[7:0];
                    else if (n_pcmd == CMD_N && n_acc <= 10'd99) begin
                        n_note = n_acc[6:0];
                        p2 = 1'b1;
                        c2 = '{start: 1'b1, note: n_acc[6:0], len: 10'd0,
                               alt: ALT_NONE, dots: 3'd0, last: 1'b0};
                    end
                end else if (n_ph == PH_NOTE_ALT || n_ph == PH_NOTE_LEN ||
                             n_ph == PH_NOTE_DOT) begin
                    p2 = 1'b1;
                    c2 = '{start: 1'b1, note: fnote, len: n_acc, alt: n_lalt,
                           dots: n_dots, last: 1'b0};
                end
            end
            n_ph = PH_IDLE; n_pcmd = CMD_NONE; n_acc = 10'd0;
            n_dots = 3'd0; n_lalt = ALT_NONE; n_halt = 1'b0;
        end
        if (p2) c2.last = 1'b1;
        else if (p1) c1.last = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_octave <= 3'd4; r_dlen <= 7'd4; r_tempo <= 8'd120;
            r_art <= ART_NORMAL; r_galt <= ALT_NONE; r_note <= 7'd0;
            r_ph <= PH_IDLE; r_pcmd <= CMD_NONE; r_acc <= 10'd0;
            r_dots <= 3'd0; r_lalt <= ALT_NONE; r_halt <= 1'b0;
            r_pend <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_IDLE && i_valid) begin
                r_c <= i_char_code; r_eos <= i_end_of_string;
            end
            if (r_state == S_PARSE) begin
                r_octave <= n_octave; r_dlen <= n_dlen; r_tempo <= n_tempo;
                r_art <= n_art; r_galt <= n_galt; r_note <= n_note;
                r_ph <= n_ph; r_pcmd <= n_pcmd; r_acc <= n_acc;
                r_dots <= n_dots; r_lalt <= n_lalt; r_halt <= n_halt;
                r_pend <= p1 && p2;
                r_pc   <= p1 ? c1 : c2;
                r_pc2  <= c2;
            end else if (r_state == S_DIV && !i_sts.busy && r_pend) begin
                r_pc   <= r_pc2;
                r_pend <= 1'b0;
            end
        end
    end

    // second request is held until the datapath frees
    always_comb begin
        n_state = r_state;
        o_cmd = r_pc;
        o_cmd.start = 1'b0;
        case (r_state)
            S_IDLE:  if (i_valid) n_state = S_PARSE;
            S_PARSE: n_state = S_DOTS;
            S_DOTS: begin
                if (r_pc.start) begin
                    if (!i_sts.busy) begin
                        o_cmd.start = 1'b1;
                        n_state = S_DIV;
                    end
                end else n_state = S_IDLE;
            end
            S_DIV: if (!i_sts.busy) n_state = r_pend ? S_OUT : S_IDLE;
            S_OUT: if (!i_sts.busy) begin
                o_cmd.start = 1'b1;
                n_state = S_EOS;
            end
            S_EOS: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_tempo          = r_tempo;
    assign o_default_length = r_dlen;
    assign o_art_mode       = r_art;
    assign o_global_alt     = r_galt;

    a_acc_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc <= 10'd999) else $error("accumulator");
    a_dots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dots <= 3'(MAX_DOTS)) else $error("dots");
    a_parse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PARSE |=> r_state == S_DOTS) else $error("parse");
endmodule

FILE: hdl/music_macro_string_player.sv
`timescale 1ns / 1ps
// Music-macro string player: one character per request, notes out as
// frequency, tone and note times. Each note runs through the bit-serial
// divider (26 steps) and then one scaling step per dot. Tempo and
// articulation are taken when a note is handed to the divider.
module music_macro_string_player (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [7:0]         i_char_code,
    input  logic               i_end_of_string,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [12:0]        o_frequency_hz,
    output logic [15:0]        o_tone_ms,
    output logic [15:0]        o_note_ms,
    output logic signed [7:0]  o_note_number,
    output logic               o_end_of_run
);
    import mmsp_pkg::*;

    t_play_cmd  w_cmd;
    t_play_sts  w_sts;
    logic [7:0] w_tempo;
    logic [6:0] w_dlen;
    logic [1:0] w_art, w_galt;

    mmsp_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_valid, .o_ready, .i_char_code, .i_end_of_string,
        .i_sts(w_sts), .o_cmd(w_cmd), .o_tempo(w_tempo),
        .o_default_length(w_dlen), .o_art_mode(w_art), .o_global_alt(w_galt)
    );

    mmsp_datapath u_dp (
        .i_clk, .i_rst_n, .i_cmd(w_cmd), .i_tempo(w_tempo),
        .i_default_length(w_dlen), .i_art_mode(w_art), .i_global_alt(w_galt),
        .o_sts(w_sts), .o_valid, .i_ready, .o_frequency_hz, .o_tone_ms,
        .o_note_ms, .o_note_number, .o_end_of_run
    );
endmodule
